// ===== design/orbit_transfer_delta_v_defines.svh =====
// ----------------------------------------------------------------------------
// Orbit transfer delta-v: assertion macros
// Shared property wrappers used by the top module of the delta-v engine.
// ----------------------------------------------------------------------------
`ifndef ORBIT_TRANSFER_DELTA_V_DEFINES_SVH
`define ORBIT_TRANSFER_DELTA_V_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OTDV_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("otdv assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define OTDV_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("otdv assertion failed: next-cycle implication");

`endif

// ===== design/otdv_pkg.sv =====
// ----------------------------------------------------------------------------
// Orbit transfer delta-v package
// Fixed field widths and constants shared by the delta-v engine.
// ----------------------------------------------------------------------------
`default_nettype none

package otdv_pkg;

    localparam int MU_BITS  = 40;
    localparam int MU_HALF  = 20;
    localparam int DV_BITS  = 42;
    localparam int SUM_BITS = 44;

    localparam logic [MU_BITS-1:0] MU_RESET = 40'd398600;

    typedef enum logic {
        t_KIND_HOHMANN    = 1'b0,
        t_KIND_BIELLIPTIC = 1'b1
    } t_kind;

endpackage

`default_nettype wire

// ===== design/otdv_div_cell.sv =====
// ----------------------------------------------------------------------------
// Division cell
// One restoring step of a long division: produces one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module otdv_div_cell #(
    parameter int DW = 65,
    parameter int QW = 113
) (
    input  wire logic          i_clk,
    input  wire logic [DW-1:0] i_rem,
    input  wire logic [QW-1:0] i_nq,
    input  wire logic [DW-1:0] i_den,
    output logic      [DW-1:0] o_rem,
    output logic      [QW-1:0] o_nq,
    output logic      [DW-1:0] o_den
);

    logic [DW:0]   shifted;
    logic [DW+1:0] diff;
    logic          ge;

    // The partial remainder stays below the divisor, so DW bits hold it.
    assign shifted = {i_rem, i_nq[QW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, i_den};
    assign ge      = ~diff[DW+1];

    always_ff @(posedge i_clk) begin
        o_rem <= ge ? diff[DW-1:0] : shifted[DW-1:0];
        o_nq  <= {i_nq[QW-2:0], ge};
        o_den <= i_den;
    end

endmodule

`default_nettype wire

// ===== design/otdv_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square-root cell
// One digit-by-digit step of an integer square root: one root bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module otdv_sqrt_cell #(
    parameter int SW = 57
) (
    input  wire logic [2*SW-1:0] i_rad,
    input  wire logic [SW:0]     i_rem,
    input  wire logic [SW-1:0]   i_root,
    input  wire logic            i_clk,
    output logic      [2*SW-1:0] o_rad,
    output logic      [SW:0]     o_rem,
    output logic      [SW-1:0]   o_root
);

    logic [SW+2:0] shifted;
    logic [SW+2:0] trial;
    logic [SW+3:0] diff;
    logic          ge;

    assign shifted = {i_rem, i_rad[2*SW-1:2*SW-2]};
    assign trial   = {1'b0, i_root, 2'b01};
    assign diff    = {1'b0, shifted} - {1'b0, trial};
    assign ge      = ~diff[SW+3];

    always_ff @(posedge i_clk) begin
        o_rem  <= ge ? diff[SW:0] : shifted[SW:0];
        o_root <= {i_root[SW-2:0], ge};
        o_rad  <= {i_rad[2*SW-3:0], 2'b00};
    end

endmodule

`default_nettype wire

// ===== design/otdv_speed_lane.sv =====
// ----------------------------------------------------------------------------
// Speed lane
// Computes isqrt(floor(mu * num * 2^(2F) / (da * db))) through a pipelined
// product stage, a row of division cells and a row of square-root cells.
// ----------------------------------------------------------------------------
`default_nettype none

module otdv_speed_lane
    import otdv_pkg::*;
#(
    parameter int R = 32,
    parameter int F = 20
) (
    input  wire logic               i_clk,
    input  wire logic [MU_BITS-1:0] i_mu,
    input  wire logic [R:0]         i_num,
    input  wire logic [R-1:0]       i_da,
    input  wire logic [R:0]         i_db,
    output logic      [((MU_BITS+R+1+2*F+1)/2)-1:0] o_speed
);

    localparam int PW = MU_BITS + R + 1;
    localparam int HW = MU_HALF + R + 1;
    localparam int QW = PW + 2*F;
    localparam int DW = 2*R + 1;
    localparam int SW = (QW + 1) / 2;

    logic [MU_BITS-1:0] r_mu;
    logic [R:0]         r_num;
    logic [R-1:0]       r_da;
    logic [R:0]         r_db;
    logic [DW-1:0]      r_den;
    logic [HW-1:0]      r_plo;
    logic [HW-1:0]      r_phi;
    logic [DW-1:0]      r_den_c;
    logic [QW-1:0]      r_n;

    logic [DW-1:0]   rem  [0:QW];
    logic [QW-1:0]   nq   [0:QW];
    logic [DW-1:0]   den  [0:QW];
    logic [2*SW-1:0] rad  [0:SW];
    logic [SW:0]     srem [0:SW];
    logic [SW-1:0]   root [0:SW];

    always_ff @(posedge i_clk) begin
        r_mu    <= i_mu;
        r_num   <= i_num;
        r_da    <= i_da;
        r_db    <= i_db;
        // Products split so no multiplier exceeds about 32 by 32 bits.
        r_den   <= DW'(r_da) * DW'(r_db);
        r_plo   <= HW'(r_mu[MU_HALF-1:0]) * HW'(r_num);
        r_phi   <= HW'(r_mu[MU_BITS-1:MU_HALF]) * HW'(r_num);
        r_den_c <= r_den;
        r_n     <= {(PW'(r_phi) << MU_HALF) + PW'(r_plo), {(2*F){1'b0}}};
    end

    assign rem[0] = '0;
    assign nq[0]  = r_n;
    assign den[0] = r_den_c;

    for (genvar g = 0; g < QW; g++) begin : g_div
        otdv_div_cell #(.DW(DW), .QW(QW)) u_cell (
            .i_clk (i_clk),
            .i_rem (rem[g]),
            .i_nq  (nq[g]),
            .i_den (den[g]),
            .o_rem (rem[g+1]),
            .o_nq  (nq[g+1]),
            .o_den (den[g+1])
        );
    end

    assign rad[0]  = (2*SW)'(nq[QW]);
    assign srem[0] = '0;
    assign root[0] = '0;

    for (genvar g = 0; g < SW; g++) begin : g_sqrt
        otdv_sqrt_cell #(.SW(SW)) u_cell (
            .i_clk  (i_clk),
            .i_rad  (rad[g]),
            .i_rem  (srem[g]),
            .i_root (root[g]),
            .o_rad  (rad[g+1]),
            .o_rem  (srem[g+1]),
            .o_root (root[g+1])
        );
    end

    assign o_speed = root[SW];

endmodule

`default_nettype wire

// ===== design/orbit_transfer_delta_v.sv =====
// ----------------------------------------------------------------------------
// Orbit transfer delta-v engine
// Burns of a Hohmann or bi-elliptic transfer between circular orbits.
// ----------------------------------------------------------------------------
// Usage: a transfer request is taken at a rising edge where start is high and
// busy is low. Busy is high during reset and until the first rising edge
// after it, then stays low, so a new request may be issued on every cycle.
// Each request yields one result, presented on the o_dv_* ports for exactly
// one cycle with o_strobe high. Results leave in request order.
// Each request passes through the product registers, the division cells
// with QW = 41 + RADIUS_BITS + 2*FRACTION_BITS, one per quotient bit, the
// square-root cells with SW = ceil(QW/2), one per root bit, and the output
// register. Throughput is one transfer per cycle: six speed lanes run side
// by side, each a row of cells that hands its word on every cycle. The
// receiver cannot stall, so nothing is held back at the output. Reset
// empties the pipeline and sets mu to 398600 (Earth). The user must write
// the mu register through i_grav_param_we only while no transfer is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module orbit_transfer_delta_v
    import otdv_pkg::*;
#(
    parameter int FRACTION_BITS = 20,
    parameter int RADIUS_BITS   = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       i_grav_param_we,
    input  wire logic [MU_BITS-1:0]         i_grav_param,
    input  wire logic                       i_kind,
    input  wire logic [RADIUS_BITS-1:0]     i_r_start,
    input  wire logic [RADIUS_BITS-1:0]     i_r_target,
    input  wire logic [RADIUS_BITS-1:0]     i_r_apo,
    output logic                            o_strobe,
    output logic signed [DV_BITS-1:0]       o_dv_first,
    output logic signed [DV_BITS-1:0]       o_dv_second,
    output logic signed [DV_BITS-1:0]       o_dv_third,
    output logic signed [SUM_BITS-1:0]      o_dv_sum
);

    `include "orbit_transfer_delta_v_defines.svh"

    localparam int R   = RADIUS_BITS;
    localparam int QW  = MU_BITS + R + 1 + 2*FRACTION_BITS;
    localparam int SW  = (QW + 1) / 2;
    localparam int LAT = 3 + QW + SW;

    logic               r_ready;
    logic [MU_BITS-1:0] r_grav_param;
    logic [LAT-1:0]     r_vpipe;
    logic [LAT-1:0]     r_kpipe;
    logic               r_kind_out;
    logic               accept;

    logic [R-1:0] r1;
    logic [R-1:0] r2;
    logic [R-1:0] rb;
    logic [R:0]   one_n;
    logic [R:0]   sum12;
    logic [R:0]   sum1b;
    logic [R:0]   sumb2;
    logic [R-1:0] oth_a;
    logic [R-1:0] rad_b;
    logic [R:0]   sum_a;
    logic [R:0]   sum_b;

    logic [R:0]   num  [0:5];
    logic [R-1:0] da   [0:5];
    logic [R:0]   db   [0:5];
    logic [SW-1:0] spd [0:5];
    logic [SUM_BITS-1:0] s [0:5];

    logic [SUM_BITS-1:0] d1;
    logic [SUM_BITS-1:0] d2;
    logic [SUM_BITS-1:0] d3;
    logic [SUM_BITS-1:0] dsum;
    t_kind               out_kind;
    logic [DV_BITS-1:0]  burn_total;

    assign busy   = ~r_ready;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready      <= 1'b0;
            r_grav_param <= MU_RESET;
            r_vpipe      <= '0;
            o_strobe     <= 1'b0;
        end else begin
            r_ready  <= 1'b1;
            r_vpipe  <= {r_vpipe[LAT-2:0], accept};
            o_strobe <= r_vpipe[LAT-1];
            if (i_grav_param_we) begin
                r_grav_param <= i_grav_param;
            end
        end
    end

    // A zero radius is taken as one kilometre, which keeps every divisor
    // non-zero.
    assign r1    = (i_r_start  == '0) ? R'(1) : i_r_start;
    assign r2    = (i_r_target == '0) ? R'(1) : i_r_target;
    assign rb    = (i_r_apo    == '0) ? R'(1) : i_r_apo;
    assign one_n = (R+1)'(1);
    assign sum12 = {1'b0, r1} + {1'b0, r2};
    assign sum1b = {1'b0, r1} + {1'b0, rb};
    assign sumb2 = {1'b0, rb} + {1'b0, r2};

    // Lanes two and three serve both kinds; the other end of the ellipse
    // is the apoapsis for the bi-elliptic case.
    assign oth_a = (i_kind == t_KIND_BIELLIPTIC) ? rb : r2;
    assign sum_a = (i_kind == t_KIND_BIELLIPTIC) ? sum1b : sum12;
    assign rad_b = (i_kind == t_KIND_BIELLIPTIC) ? rb : r2;
    assign sum_b = sum_a;

    // Circular speeds at start and target.
    assign num[0] = one_n;         assign da[0] = r1;    assign db[0] = one_n;
    assign num[1] = one_n;         assign da[1] = r2;    assign db[1] = one_n;
    // First ellipse at its periapsis, and at its far end.
    assign num[2] = {oth_a, 1'b0}; assign da[2] = r1;    assign db[2] = sum_a;
    assign num[3] = {r1, 1'b0};    assign da[3] = rad_b; assign db[3] = sum_b;
    // Second ellipse of a bi-elliptic transfer, at the apoapsis and at target.
    assign num[4] = {r2, 1'b0};    assign da[4] = rb;    assign db[4] = sumb2;
    assign num[5] = {rb, 1'b0};    assign da[5] = r2;    assign db[5] = sumb2;

    for (genvar g = 0; g < 6; g++) begin : g_lane
        otdv_speed_lane #(.R(R), .F(FRACTION_BITS)) u_lane (
            .i_clk   (i_clk),
            .i_mu    (r_grav_param),
            .i_num   (num[g]),
            .i_da    (da[g]),
            .i_db    (db[g]),
            .o_speed (spd[g])
        );
        assign s[g] = SUM_BITS'(spd[g]);
    end

    always_ff @(posedge i_clk) begin
        r_kpipe <= {r_kpipe[LAT-2:0], i_kind};
    end

    assign out_kind = t_kind'(r_kpipe[LAT-1]);

    // Burns are formed modulo 2^SUM_BITS; each burn field keeps its low bits.
    always_comb begin
        d1 = s[2] - s[0];
        if (out_kind == t_KIND_BIELLIPTIC) begin
            d2 = s[4] - s[3];
            d3 = s[1] - s[5];
        end else begin
            d2 = s[1] - s[3];
            d3 = '0;
        end
        dsum = d1 + d2 + d3;
    end

    always_ff @(posedge i_clk) begin
        o_dv_first  <= d1[DV_BITS-1:0];
        o_dv_second <= d2[DV_BITS-1:0];
        o_dv_third  <= d3[DV_BITS-1:0];
        o_dv_sum    <= dsum;
        r_kind_out  <= r_kpipe[LAT-1];
    end

    // Low bits of the sum of the three burn fields, for the sum check.
    assign burn_total = o_dv_first + o_dv_second + o_dv_third;

    `OTDV_ASSERT_IMP(a_strobe_has_request, i_clk, i_rst_n, o_strobe, $past(accept, LAT + 1))
    `OTDV_ASSERT_IMP(a_hohmann_no_third, i_clk, i_rst_n, o_strobe && !r_kind_out, o_dv_third == '0)
    `OTDV_ASSERT_IMP(a_sum_matches, i_clk, i_rst_n, o_strobe, o_dv_sum[DV_BITS-1:0] == burn_total)
    `OTDV_ASSERT_NXT(a_request_gives_strobe, i_clk, i_rst_n, r_vpipe[LAT-1], o_strobe)

endmodule

`default_nettype wire
